// ===== rtl/tcgp_pkg.sv =====
// Shared types, codes and the glyph table of the text console glyph placer.
`timescale 1ns / 1ps

package tcgp_pkg;

    // Result kinds, as carried on m_tuser
    localparam logic [1:0] KIND_GLYPH  = 2'd0;
    localparam logic [1:0] KIND_COLOUR = 2'd1;
    localparam logic [1:0] KIND_CUSTOM = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_X      = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y      = 2'd1;
    localparam logic [1:0] CFG_DRAW_ENABLE   = 2'd2;
    localparam logic [1:0] CFG_CUSTOM_ENABLE = 2'd3;

    localparam int unsigned FONT_COLS = 26;
    localparam logic [7:0]  NO_GLYPH  = 8'hFF;
    localparam logic [7:0]  COL_MAX   = 8'd255;
    localparam logic [6:0]  ROW_MAX   = 7'd127;

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_FIRST   = 8'h21;
    localparam logic [7:0] CHAR_LAST    = 8'hDF;
    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_LOWER_C = 8'h63;
    localparam logic [7:0] CHAR_LOWER_M = 8'h6D;

    // Glyph index for bytes 0x20..0xDF; NO_GLYPH where the font has none
    localparam logic [7:0] GLYPH_ROM [192] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd66,  8'd63,  8'd76,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd125, 8'd62,  8'd126, 8'd75,
        8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
        8'd60,  8'd61,  8'd65,  8'd255, 8'd73,  8'd255, 8'd70,  8'd74,
        8'd255, 8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,
        8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,
        8'd15,  8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,
        8'd23,  8'd24,  8'd25,  8'd68,  8'd255, 8'd69,  8'd64,  8'd255,
        8'd255, 8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,  8'd32,
        8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,  8'd40,
        8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,
        8'd49,  8'd50,  8'd51,  8'd255, 8'd255, 8'd255, 8'd67,  8'd255,
        8'd139, 8'd140, 8'd142, 8'd141, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd126, 8'd255, 8'd255, 8'd125, 8'd72,  8'd123, 8'd130,
        8'd131, 8'd132, 8'd133, 8'd134, 8'd136, 8'd137, 8'd138, 8'd135,
        8'd71,  8'd78,  8'd79,  8'd80,  8'd81,  8'd82,  8'd83,  8'd84,
        8'd85,  8'd86,  8'd87,  8'd88,  8'd89,  8'd90,  8'd91,  8'd92,
        8'd93,  8'd94,  8'd95,  8'd96,  8'd97,  8'd98,  8'd99,  8'd100,
        8'd101, 8'd102, 8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109,
        8'd110, 8'd111, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117,
        8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd124, 8'd127, 8'd128
    };

    // Live configuration
    typedef struct packed {
        logic [9:0] origin_x;
        logic [9:0] origin_y;
        logic       draw_enable;
        logic       custom_enable;
    } cfg_t;

    // Classified command from the front end to the back end.
    // aux: glyph index (glyph), colour index in low bits (colour), raw byte (custom)
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] column;
        logic [6:0] row;
        logic [7:0] aux;
    } cmd_t;

endpackage

// ===== rtl/text_console_glyph_placer.sv =====
// Top level of the text console glyph placer: configuration registers and stream ports.
`timescale 1ns / 1ps

// Takes one text byte per clock on the s_ stream while the command queue has
// room, and keeps a cursor (column, row) and an escape state. Printable bytes
// advance the column and, when the font has a glyph and drawing is enabled,
// produce a glyph rectangle result with its pixel position and texture S/T.
// Tab moves the column to the next multiple of 4, newline starts a new row,
// "@c<byte>" emits a colour change from the byte's low 3 bits when drawing is
// enabled and "@m<byte>" emits a custom draw at the cursor when custom draws
// are enabled. Column saturates at 255 and row at 127; start_of_text in tuser
// clears the cursor and escape state before its byte is handled, and tlast has
// no effect. Throughput is one byte per cycle while the queue has room: the
// front end decodes and updates the cursor on each transfer, so every byte is
// taken as soon as it arrives. A result is written into the command queue when
// its byte is transferred, then loaded into the output register that drives m_. s_tready
// drops only when the QUEUE_DEPTH-entry command queue is full because m_tready
// is held low. Configuration writes are always accepted (cfg_ready is tied
// high) and must only be made while no results are pending.
module text_console_glyph_placer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,

    // text byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] start_of_text
    input  logic        s_tlast,   // last_byte

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [11:0] x_pos, [23:12] y_pos, [36:24] tex_s,
                                   // [47:37] tex_t, [55:48] raw_code, [63:56] red,
                                   // [71:64] green, [79:72] blue
    output logic [1:0]  m_tuser    // [1:0] kind
);

    tcgp_pkg::cfg_t cfg_reg;
    tcgp_pkg::cmd_t front_cmd;
    tcgp_pkg::cmd_t queue_cmd;

    logic in_accept;
    logic front_valid;
    logic queue_full;
    logic queue_empty;
    logic back_pop;
    logic end_mark;

    // end-of-string mark carries no meaning here; escapes span strings
    assign end_mark = s_tlast;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x      <= 10'd0;
            cfg_reg.origin_y      <= 10'd0;
            cfg_reg.draw_enable   <= 1'b1;
            cfg_reg.custom_enable <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tcgp_pkg::CFG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data;
                tcgp_pkg::CFG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data;
                tcgp_pkg::CFG_DRAW_ENABLE:   cfg_reg.draw_enable   <= cfg_data[0];
                tcgp_pkg::CFG_CUSTOM_ENABLE: cfg_reg.custom_enable <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // take a byte whenever the queue has room for its possible result
    assign s_tready  = !queue_full;
    assign in_accept = s_tvalid && s_tready && (end_mark || !end_mark);

    tcgp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_accept     (in_accept),
        .char_code     (s_tdata),
        .start_of_text (s_tuser),
        .cmd_valid     (front_valid),
        .cmd           (front_cmd)
    );

    tcgp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_data (front_cmd),
        .pop       (back_pop),
        .pop_data  (queue_cmd),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    tcgp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_avail (!queue_empty),
        .cmd       (queue_cmd),
        .cmd_pop   (back_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/tcgp_front.sv =====
// Front end: escape decoding, cursor tracking and glyph lookup per text byte.
`timescale 1ns / 1ps

module tcgp_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  tcgp_pkg::cfg_t cfg,
    input  logic           in_accept,
    input  logic [7:0]     char_code,
    input  logic           start_of_text,
    output logic           cmd_valid,
    output tcgp_pkg::cmd_t cmd
);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_AT     = 2'd1;
    localparam logic [1:0] MODE_COLOUR = 2'd2;
    localparam logic [1:0] MODE_CUSTOM = 2'd3;

    logic [1:0] mode_reg, mode_next;
    logic [7:0] col_reg, col_next;
    logic [6:0] row_reg, row_next;

    logic [1:0] mode_cur;
    logic [7:0] col_cur;
    logic [6:0] row_cur;
    logic       in_range;
    logic [7:0] rom_idx;
    logic [7:0] glyph;
    logic [8:0] tab_col;
    logic       plain;

    assign mode_cur = start_of_text ? MODE_NORMAL : mode_reg;
    assign col_cur  = start_of_text ? 8'd0 : col_reg;
    assign row_cur  = start_of_text ? 7'd0 : row_reg;

    assign in_range = (char_code >= tcgp_pkg::CHAR_FIRST) && (char_code <= tcgp_pkg::CHAR_LAST);
    assign rom_idx  = in_range ? (char_code - tcgp_pkg::CHAR_SPACE) : 8'd0;
    assign glyph    = tcgp_pkg::GLYPH_ROM[rom_idx];
    assign tab_col  = ({1'b0, col_cur} + 9'd4) & 9'h1FC;

    always_comb begin
        mode_next  = MODE_NORMAL;
        col_next   = col_cur;
        row_next   = row_cur;
        cmd_valid  = 1'b0;
        cmd.kind   = tcgp_pkg::KIND_GLYPH;
        cmd.column = col_cur;
        cmd.row    = row_cur;
        cmd.aux    = char_code;
        plain      = 1'b0;

        case (mode_cur)
            MODE_COLOUR: begin
                cmd.kind  = tcgp_pkg::KIND_COLOUR;
                cmd_valid = cfg.draw_enable;
            end
            MODE_CUSTOM: begin
                cmd.kind  = tcgp_pkg::KIND_CUSTOM;
                cmd_valid = cfg.custom_enable;
            end
            MODE_AT: begin
                if (char_code == tcgp_pkg::CHAR_LOWER_C) begin
                    mode_next = MODE_COLOUR;
                end else if (char_code == tcgp_pkg::CHAR_LOWER_M) begin
                    mode_next = MODE_CUSTOM;
                end else begin
                    plain = 1'b1;
                end
            end
            default: begin
                plain = 1'b1;
            end
        endcase

        if (plain) begin
            if (char_code == tcgp_pkg::CHAR_AT) begin
                mode_next = MODE_AT;
            end else if (char_code < tcgp_pkg::CHAR_SPACE) begin
                if (char_code == tcgp_pkg::CHAR_TAB) begin
                    col_next = tab_col[8] ? tcgp_pkg::COL_MAX : tab_col[7:0];
                end else if (char_code == tcgp_pkg::CHAR_NEWLINE) begin
                    col_next = 8'd0;
                    if (row_cur < tcgp_pkg::ROW_MAX) begin
                        row_next = row_cur + 7'd1;
                    end
                end
            end else begin
                cmd.kind  = tcgp_pkg::KIND_GLYPH;
                cmd.aux   = glyph;
                cmd_valid = cfg.draw_enable && in_range && (glyph != tcgp_pkg::NO_GLYPH);
                if (col_cur < tcgp_pkg::COL_MAX) begin
                    col_next = col_cur + 8'd1;
                end
            end
        end
        // hold everything unless a byte is transferred
        if (!in_accept) begin
            cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            col_reg  <= 8'd0;
            row_reg  <= 7'd0;
        end else if (in_accept) begin
            mode_reg <= mode_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

// ===== rtl/tcgp_queue.sv =====
// Small command queue between the front end and the back end.
`timescale 1ns / 1ps

module tcgp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tcgp_pkg::cmd_t push_data,
    input  logic           pop,
    output tcgp_pkg::cmd_t pop_data,
    output logic           full,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tcgp_pkg::cmd_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/tcgp_back.sv =====
// Back end: pixel position, texture coordinates and colour, into the output register.
`timescale 1ns / 1ps

module tcgp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  tcgp_pkg::cfg_t cfg,
    input  logic           cmd_avail,
    input  tcgp_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [79:0]    m_tdata,
    output logic [1:0]     m_tuser
);

    localparam logic [7:0] Q1 = 8'(tcgp_pkg::FONT_COLS * 1);
    localparam logic [7:0] Q2 = 8'(tcgp_pkg::FONT_COLS * 2);
    localparam logic [7:0] Q3 = 8'(tcgp_pkg::FONT_COLS * 3);
    localparam logic [7:0] Q4 = 8'(tcgp_pkg::FONT_COLS * 4);
    localparam logic [7:0] Q5 = 8'(tcgp_pkg::FONT_COLS * 5);

    logic        valid_reg, valid_next;
    logic [79:0] data_reg;
    logic [1:0]  kind_reg;
    logic [79:0] data_next;

    logic [2:0]  quot;
    logic [7:0]  base;
    logic [4:0]  rem;
    logic [11:0] x_pos, y_pos;
    logic [12:0] tex_s;
    logic [10:0] tex_t;
    logic [7:0]  raw_code, red, green, blue;
    logic        placed;

    // glyph index split into font row and column
    always_comb begin
        if (cmd.aux >= Q5) begin
            quot = 3'd5; base = Q5;
        end else if (cmd.aux >= Q4) begin
            quot = 3'd4; base = Q4;
        end else if (cmd.aux >= Q3) begin
            quot = 3'd3; base = Q3;
        end else if (cmd.aux >= Q2) begin
            quot = 3'd2; base = Q2;
        end else if (cmd.aux >= Q1) begin
            quot = 3'd1; base = Q1;
        end else begin
            quot = 3'd0; base = 8'd0;
        end
    end

    assign rem    = 5'(cmd.aux - base);
    assign placed = (cmd.kind == tcgp_pkg::KIND_GLYPH) || (cmd.kind == tcgp_pkg::KIND_CUSTOM);

    always_comb begin
        x_pos    = 12'd0;
        y_pos    = 12'd0;
        tex_s    = 13'd0;
        tex_t    = 11'd0;
        raw_code = 8'd0;
        red      = 8'd0;
        green    = 8'd0;
        blue     = 8'd0;
        if (placed) begin
            x_pos = {2'b0, cfg.origin_x} + {2'b0, cmd.column, 2'b0} + {3'b0, cmd.column, 1'b0};
            y_pos = {2'b0, cfg.origin_y} + {2'b0, cmd.row, 3'b0};
        end
        case (cmd.kind)
            tcgp_pkg::KIND_GLYPH: begin
                tex_s = {1'b0, rem, 7'b0} + {2'b0, rem, 6'b0};
                tex_t = {quot, 8'b0};
            end
            tcgp_pkg::KIND_COLOUR: begin
                red   = cmd.aux[2] ? 8'hFF : 8'h00;
                green = cmd.aux[1] ? 8'hFF : 8'h00;
                blue  = cmd.aux[0] ? 8'hFF : 8'h00;
            end
            tcgp_pkg::KIND_CUSTOM: begin
                raw_code = cmd.aux;
            end
            default: begin
            end
        endcase
    end

    assign data_next = {blue, green, red, raw_code, tex_t, tex_s, y_pos, x_pos};

    // load a new result whenever the output register is empty or being drained
    assign cmd_pop    = cmd_avail && (!valid_reg || m_tready);
    assign valid_next = cmd_pop ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            data_reg <= data_next;
            kind_reg <= cmd.kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

endmodule

// ===== test/text_console_glyph_placer_tb.sv =====
// Self-checking testbench for the text console glyph placer: stimulus, predictor and checker.
`timescale 1ns / 1ps

module text_console_glyph_placer_tb;

    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
    localparam int TARGET_BYTES  = 1050;
    localparam int DRAIN_LIMIT   = 3000;    // cycles to wait for missing results
    localparam int SETTLE_CYCLES = 8;       // settling margin after the last result
    localparam int LONG_HOLD     = 400;     // receiver hold-off used to back up the block
    localparam int REPORT_LIMIT  = 10;
    localparam int TEX_S_STEP    = 'hC0;
    localparam int TEX_T_STEP    = 'h100;

    // Shapes of generated text runs
    localparam int FLAVOR_MIXED = 0;
    localparam int FLAVOR_LINE  = 1;  // one long line: drives the column into its limit
    localparam int FLAVOR_ROWS  = 2;  // mostly newlines: drives the row into its limit

    typedef enum logic [2:0] {
        ESC_NORMAL,
        ESC_AT,
        ESC_COLOUR,
        ESC_CUSTOM
    } esc_mode_t;

    // One text byte waiting to be sent
    typedef struct packed {
        logic [7:0] code;
        logic       sot;
        logic       end_mark;
    } text_byte_t;

    // Laid out so that {m_tuser, m_tdata} maps onto it directly
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  raw_code;
        logic [10:0] tex_t;
        logic [12:0] tex_s;
        logic [11:0] y_pos;
        logic [11:0] x_pos;
    } placement_t;

    // Font cell of each byte from 0x20 to 0xDF; 255 marks a byte the font lacks
    localparam logic [7:0] FONT_INDEX [192] = '{
        255,255,255,255,255, 66, 63, 76,255,255,255,255,125, 62,126, 75,
         52, 53, 54, 55, 56, 57, 58, 59, 60, 61, 65,255, 73,255, 70, 74,
        255,  0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14,
         15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 68,255, 69, 64,255,
        255, 26, 27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39, 40,
         41, 42, 43, 44, 45, 46, 47, 48, 49, 50, 51,255,255,255, 67,255,
        139,140,142,141,255,255,255,255,255,255,255,255,255,255,255,255,
        255,255,255,255,255,255,255,255,255,255,255,255,255,255,255,255,
        255,126,255,255,125, 72,123,130,131,132,133,134,136,137,138,135,
         71, 78, 79, 80, 81, 82, 83, 84, 85, 86, 87, 88, 89, 90, 91, 92,
         93, 94, 95, 96, 97, 98, 99,100,101,102,104,105,106,107,108,109,
        110,111,112,113,114,115,116,117,118,119,120,121,122,124,127,128
    };

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = tcgp_pkg::CFG_ORIGIN_X;
    logic [9:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    always #5 aclk = ~aclk;

    text_console_glyph_placer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    text_byte_t text_bytes [$];      // bytes waiting for the sender
    placement_t expected_draws [$];  // predicted results, oldest first

    bit s_fired;                     // a byte transfer happened at the last rising edge
    bit m_fired;                     // a result transfer happened at the last rising edge
    bit sender_idle   = 1'b1;        // sender inserts random gaps
    bit receiver_idle = 1'b1;        // receiver inserts random stalls
    int send_gap;
    int ready_wait;
    int hold_count;                  // long receiver hold-off, counted down below
    int cycle_count;

    int faults;
    int bytes_queued;
    int bytes_sent;
    int glyphs_seen, colours_seen, customs_seen;
    int settings_count;
    int col_limit_hits, row_limit_hits;

    // Predictor copy of the block's registers and cursor
    logic [9:0] org_x, org_y;
    logic       draw_on, custom_on;
    esc_mode_t  esc_state;
    logic [7:0] cur_col;
    logic [6:0] cur_row;

    // ------------------------------------------------------------------
    // Predictor: advance the cursor model by one byte, return 1 with the
    // expected result when the byte produces one
    // ------------------------------------------------------------------
    function automatic bit place_text_byte(input logic [7:0] c, input logic sot,
                                           output placement_t r);
        logic [8:0] tab_col;
        int         glyph_idx;
        bit         made;

        r    = '0;
        made = 1'b0;
        if (sot) begin
            cur_col   = '0;
            cur_row   = '0;
            esc_state = ESC_NORMAL;
        end

        case (esc_state)
            ESC_COLOUR: begin
                // the byte after "@c" is always consumed; only its low 3 bits matter
                esc_state = ESC_NORMAL;
                if (!draw_on)
                    return 1'b0;
                r.kind  = tcgp_pkg::KIND_COLOUR;
                r.red   = {8{c[2]}};
                r.green = {8{c[1]}};
                r.blue  = {8{c[0]}};
                return 1'b1;
            end
            ESC_CUSTOM: begin
                // custom draw at the cursor; the cursor holds still
                esc_state = ESC_NORMAL;
                if (!custom_on)
                    return 1'b0;
                r.kind     = tcgp_pkg::KIND_CUSTOM;
                r.x_pos    = 12'(int'(org_x) + int'(cur_col) * 6);
                r.y_pos    = 12'(int'(org_y) + int'(cur_row) * 8);
                r.raw_code = c;
                return 1'b1;
            end
            ESC_AT: begin
                esc_state = ESC_NORMAL;
                if (c == tcgp_pkg::CHAR_LOWER_C) begin
                    esc_state = ESC_COLOUR;
                    return 1'b0;
                end
                if (c == tcgp_pkg::CHAR_LOWER_M) begin
                    esc_state = ESC_CUSTOM;
                    return 1'b0;
                end
                // anything else falls through and is handled as a plain byte
            end
            default: ;
        endcase

        if (c == tcgp_pkg::CHAR_AT) begin
            esc_state = ESC_AT;
        end else if (c < tcgp_pkg::CHAR_SPACE) begin
            if (c == tcgp_pkg::CHAR_TAB) begin
                tab_col = ({1'b0, cur_col} + 9'd4) & ~9'd3;
                if (tab_col > 9'(tcgp_pkg::COL_MAX)) begin
                    cur_col = tcgp_pkg::COL_MAX;
                    col_limit_hits++;
                end else begin
                    cur_col = tab_col[7:0];
                end
            end else if (c == tcgp_pkg::CHAR_NEWLINE) begin
                cur_col = '0;
                if (cur_row < tcgp_pkg::ROW_MAX)
                    cur_row++;
                else
                    row_limit_hits++;
            end
        end else begin
            if (draw_on && c >= tcgp_pkg::CHAR_FIRST && c <= tcgp_pkg::CHAR_LAST
                    && FONT_INDEX[c - tcgp_pkg::CHAR_SPACE] != tcgp_pkg::NO_GLYPH) begin
                glyph_idx = int'(FONT_INDEX[c - tcgp_pkg::CHAR_SPACE]);
                r.kind  = tcgp_pkg::KIND_GLYPH;
                r.x_pos = 12'(int'(org_x) + int'(cur_col) * 6);
                r.y_pos = 12'(int'(org_y) + int'(cur_row) * 8);
                r.tex_s = 13'((glyph_idx % tcgp_pkg::FONT_COLS) * TEX_S_STEP);
                r.tex_t = 11'((glyph_idx / tcgp_pkg::FONT_COLS) * TEX_T_STEP);
                made    = 1'b1;
            end
            if (cur_col < tcgp_pkg::COL_MAX)
                cur_col++;
            else
                col_limit_hits++;
        end
        return made;
    endfunction

    // ------------------------------------------------------------------
    // Rising edge: record transfers, predict accepted bytes, check results
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : track_and_check
        placement_t want, got;
        bit         made;

        if (!aresetn) begin
            s_fired   <= 1'b0;
            m_fired   <= 1'b0;
            org_x     = '0;
            org_y     = '0;
            draw_on   = 1'b1;
            custom_on = 1'b0;
            esc_state = ESC_NORMAL;
            cur_col   = '0;
            cur_row   = '0;
        end else begin
            s_fired <= s_tvalid && s_tready;
            m_fired <= m_tvalid && m_tready;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tcgp_pkg::CFG_ORIGIN_X:      org_x     = cfg_data;
                    tcgp_pkg::CFG_ORIGIN_Y:      org_y     = cfg_data;
                    tcgp_pkg::CFG_DRAW_ENABLE:   draw_on   = cfg_data[0];
                    tcgp_pkg::CFG_CUSTOM_ENABLE: custom_on = cfg_data[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                bytes_sent++;
                made = place_text_byte(s_tdata, s_tuser, want);
                if (made)
                    expected_draws.push_back(want);
            end

            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (expected_draws.size() == 0) begin
                    faults++;
                    if (faults <= REPORT_LIMIT)
                        $display("%0t: unexpected result kind %0d x %0d y %0d",
                                 $realtime, got.kind, got.x_pos, got.y_pos);
                end else begin
                    want = expected_draws.pop_front();
                    if (got.kind !== want.kind || got.x_pos !== want.x_pos
                            || got.y_pos !== want.y_pos || got.tex_s !== want.tex_s
                            || got.tex_t !== want.tex_t || got.raw_code !== want.raw_code
                            || got.red !== want.red || got.green !== want.green
                            || got.blue !== want.blue) begin
                        faults++;
                        if (faults <= REPORT_LIMIT) begin
                            $display("%0t: mismatch (expected/actual) kind %0d/%0d x %0d/%0d",
                                     $realtime, want.kind, got.kind, want.x_pos, got.x_pos);
                            $display("    y %0d/%0d s %0d/%0d t %0d/%0d raw %h/%h",
                                     want.y_pos, got.y_pos, want.tex_s, got.tex_s,
                                     want.tex_t, got.tex_t, want.raw_code, got.raw_code);
                            $display("    rgb %h%h%h/%h%h%h", want.red, want.green,
                                     want.blue, got.red, got.green, got.blue);
                        end
                    end else begin
                        case (want.kind)
                            tcgp_pkg::KIND_GLYPH:  glyphs_seen++;
                            tcgp_pkg::KIND_COLOUR: colours_seen++;
                            default:               customs_seen++;
                        endcase
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: present queued bytes, hold each until its transfer, then
    // idle for a randomly drawn gap
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_text
        text_byte_t nb;

        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && !s_fired) begin
            // hold the current byte
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (text_bytes.size() != 0) begin
            nb       = text_bytes.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= nb.code;
            s_tuser  <= nb.sot;
            s_tlast  <= nb.end_mark;
            send_gap <= sender_idle ? int'($urandom_range(0, 13)) : 0;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Long receiver hold-off: count down whatever the stimulus loads
    always @(negedge aclk) begin
        if (hold_count > 0)
            hold_count <= hold_count - 1;
    end

    // ------------------------------------------------------------------
    // Receiver: after each result transfer, stall for a drawn number of
    // cycles; drop ready entirely during the long hold-off
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_ready
        int w;

        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_wait <= 0;
        end else if (hold_count > 0) begin
            m_tready <= 1'b0;
        end else if (m_fired) begin
            w = receiver_idle ? int'($urandom_range(0, 13)) : 0;
            if (w == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                ready_wait <= w - 1;
            end
        end else if (ready_wait > 0) begin
            m_tready   <= 1'b0;
            ready_wait <= ready_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_draws.size());
            $display("text_console_glyph_placer_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; they run just after a rising edge so that queue
    // updates never race the clocked blocks
    // ------------------------------------------------------------------
    task automatic tick();
        @(posedge aclk);
        #1;
    endtask

    task automatic queue_byte(input logic [7:0] c, input logic sot, input logic end_mark);
        text_byte_t tb_byte;
        tb_byte.code     = c;
        tb_byte.sot      = sot;
        tb_byte.end_mark = end_mark;
        text_bytes.push_back(tb_byte);
        bytes_queued++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        tick();
    endtask

    task automatic apply_settings(input logic [9:0] ox, input logic [9:0] oy,
                                  input logic de, input logic ce);
        write_reg(tcgp_pkg::CFG_ORIGIN_X, ox);
        write_reg(tcgp_pkg::CFG_ORIGIN_Y, oy);
        write_reg(tcgp_pkg::CFG_DRAW_ENABLE, {9'd0, de});
        write_reg(tcgp_pkg::CFG_CUSTOM_ENABLE, {9'd0, ce});
        settings_count++;
    endtask

    // Wait for the sender to empty and every predicted result to arrive, then
    // let the block go quiet so that a register write finds it idle
    task automatic wait_idle();
        int waited;
        while (text_bytes.size() != 0 || s_tvalid)
            tick();
        waited = 0;
        while (expected_draws.size() != 0 && waited < DRAIN_LIMIT) begin
            tick();
            waited++;
        end
        if (expected_draws.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $realtime, expected_draws.size());
            faults += expected_draws.size();
            expected_draws.delete();
        end
        repeat (SETTLE_CYCLES)
            tick();
    endtask

    // Queue a run of text built from tokens of one to three bytes
    task automatic queue_text_run(input int len, input int flavor);
        logic [7:0] tok [$];
        int         pick, n;
        logic       sot, end_mark;

        n = 0;
        while (n < len) begin
            tok.delete();
            pick = $urandom_range(0, 99);
            case (flavor)
                FLAVOR_LINE: begin
                    if (pick < 85)
                        tok.push_back(8'($urandom_range(32, 126)));
                    else if (pick < 95)
                        tok.push_back(tcgp_pkg::CHAR_TAB);
                    else
                        tok = '{tcgp_pkg::CHAR_AT, tcgp_pkg::CHAR_LOWER_C, 8'($urandom)};
                end
                FLAVOR_ROWS: begin
                    if (pick < 80)
                        tok.push_back(tcgp_pkg::CHAR_NEWLINE);
                    else if (pick < 95)
                        tok.push_back(8'($urandom_range(32, 126)));
                    else
                        tok = '{tcgp_pkg::CHAR_AT, tcgp_pkg::CHAR_LOWER_M, 8'($urandom)};
                end
                default: begin
                    if (pick < 45)
                        tok.push_back(8'($urandom_range(32, 126)));
                    else if (pick < 55)
                        tok.push_back(8'($urandom_range(128, 255)));
                    else if (pick < 63)
                        tok = '{tcgp_pkg::CHAR_AT, tcgp_pkg::CHAR_LOWER_C, 8'($urandom)};
                    else if (pick < 70)
                        tok = '{tcgp_pkg::CHAR_AT, tcgp_pkg::CHAR_LOWER_M, 8'($urandom)};
                    else if (pick < 74)
                        tok = '{tcgp_pkg::CHAR_AT, 8'($urandom)};
                    else if (pick < 80)
                        tok.push_back(tcgp_pkg::CHAR_NEWLINE);
                    else if (pick < 86)
                        tok.push_back(tcgp_pkg::CHAR_TAB);
                    else if (pick < 91)
                        tok.push_back(8'($urandom_range(0, 31)));
                    else
                        tok.push_back(8'($urandom));
                end
            endcase
            foreach (tok[i]) begin
                // mostly start each run fresh; now and then restart mid-run
                if (n == 0)
                    sot = ($urandom_range(0, 7) != 0);
                else
                    sot = (flavor == FLAVOR_MIXED) && ($urandom_range(0, 63) == 0);
                end_mark = (n >= len - 1) || ($urandom_range(0, 31) == 0);
                queue_byte(tok[i], sot, end_mark);
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int phase;
        int phase_start;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tick();

        // Directed, reset settings: glyph, font hole, last font byte, a byte
        // past the font, space, tab, newline, ignored control byte
        queue_byte(8'h41, 1'b1, 1'b0);
        queue_byte(tcgp_pkg::CHAR_FIRST, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_LAST, 1'b0, 1'b0);
        queue_byte(8'hE0, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_SPACE, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_TAB, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        // colour from a non-digit byte: only the low bits count
        queue_byte(tcgp_pkg::CHAR_AT, 1'b1, 1'b0);
        queue_byte(tcgp_pkg::CHAR_LOWER_C, 1'b0, 1'b0);
        queue_byte(8'hF7, 1'b0, 1'b0);
        // a second '@' arms the escape again
        queue_byte(tcgp_pkg::CHAR_AT, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_AT, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_LOWER_C, 1'b0, 1'b0);
        queue_byte(8'h02, 1'b0, 1'b0);
        // escape survives the end of a string; custom draw is off here
        queue_byte(tcgp_pkg::CHAR_AT, 1'b0, 1'b1);
        queue_byte(tcgp_pkg::CHAR_LOWER_M, 1'b0, 1'b0);
        queue_byte(8'h33, 1'b0, 1'b0);
        // start of text drops a pending colour escape
        queue_byte(tcgp_pkg::CHAR_AT, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_LOWER_C, 1'b0, 1'b0);
        queue_byte(8'h41, 1'b1, 1'b1);
        wait_idle();

        // Directed, far origin with drawing off and custom draws on
        apply_settings(10'd1023, 10'd1023, 1'b0, 1'b1);
        queue_byte(8'h41, 1'b1, 1'b0);
        queue_byte(tcgp_pkg::CHAR_AT, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_LOWER_C, 1'b0, 1'b0);
        queue_byte(8'h07, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_AT, 1'b0, 1'b0);
        queue_byte(tcgp_pkg::CHAR_LOWER_M, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        wait_idle();

        // Push the column and then the row into their limits at the far origin
        apply_settings(10'd1023, 10'd1023, 1'b1, 1'b1);
        queue_text_run(280, FLAVOR_LINE);
        queue_text_run(180, FLAVOR_ROWS);
        wait_idle();

        // Random phases, each under its own register setting
        phase = 0;
        while (bytes_queued < TARGET_BYTES) begin
            sender_idle   = 1'b1;
            receiver_idle = 1'b1;
            case (phase % 6)
                0: apply_settings(10'd0, 10'd0, 1'b1, 1'b1);
                1: begin
                    // back the block up: receiver holds off while bytes keep coming
                    apply_settings(10'd1023, 10'd0, 1'b1, 1'b1);
                    sender_idle = 1'b0;
                    hold_count  = LONG_HOLD;
                end
                2: apply_settings(10'($urandom), 10'($urandom), 1'b1, 1'b0);
                3: apply_settings(10'($urandom), 10'($urandom), 1'b0, 1'b1);
                4: begin
                    apply_settings(10'($urandom), 10'($urandom), 1'b1, 1'b1);
                    sender_idle   = 1'b0;
                    receiver_idle = 1'b0;
                end
                default: apply_settings(10'($urandom), 10'($urandom),
                                        1'($urandom_range(0, 1)), 1'b1);
            endcase
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 140 && bytes_queued < TARGET_BYTES)
                queue_text_run($urandom_range(1, 40), FLAVOR_MIXED);
            wait_idle();
            phase++;
        end

        $display("covered %0d text bytes and %0d glyph, %0d colour, %0d custom results",
                 bytes_sent, glyphs_seen, colours_seen, customs_seen);
        $display("over %0d register settings; column limit reached %0d times, row %0d times",
                 settings_count, col_limit_hits, row_limit_hits);
        if (faults == 0)
            $display("text_console_glyph_placer_tb: PASS");
        else
            $display("text_console_glyph_placer_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tcgp_pkg.sv
rtl/tcgp_front.sv
rtl/tcgp_queue.sv
rtl/tcgp_back.sv
rtl/text_console_glyph_placer.sv
test/text_console_glyph_placer_tb.sv
